// ===== src/suspicious_pipe_prefix_matcher_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pipe-name prefix matcher
// Clocked, reset-qualified wrappers for implication checks.
// ----------------------------------------------------------------------------
`ifndef SUSPICIOUS_PIPE_PREFIX_MATCHER_TOP_ASSERT_SVH
`define SUSPICIOUS_PIPE_PREFIX_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication
`define SPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Pattern table, widths and per-lane step function for the matcher.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int NUM_PATTERNS    = 5;
    localparam int MAX_PATTERN_LEN = 16;
    localparam int TEXT_SLOTS      = 32;
    localparam int UNIT_W          = 16;
    localparam int PROG_W          = $clog2(MAX_PATTERN_LEN + 1);

    localparam logic [UNIT_W-1:0] BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] UPPER_A   = 16'h0041;
    localparam logic [UNIT_W-1:0] UPPER_Z   = 16'h005A;
    localparam logic [UNIT_W-1:0] CASE_OFS  = 16'h0020;

    typedef logic [PROG_W-1:0] prog_t;

    typedef struct packed {
        prog_t prog;
        logic  hit;
    } spm_lane_t;

    typedef struct packed {
        logic hit_seen;
        logic busy;
    } spm_status_t;

    // Raw pattern text, right-aligned in a fixed slot
    function automatic logic [8*TEXT_SLOTS-1:0] pat_text(input int p);
        logic [8*TEXT_SLOTS-1:0] s;
        s = '0;
        case (p)
            0:       s = "\\msse-";
            1:       s = "\\msagent_";
            2:       s = "\\postex_";
            3:       s = "\\status_";
            4:       s = "\\mojo.5688.8052.";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic int pat_len(input int p);
        int n;
        n = 0;
        case (p)
            0:       n = 6;
            1:       n = 9;
            2:       n = 8;
            3:       n = 8;
            4:       n = 16;
            default: n = 0;
        endcase
        return n;
    endfunction

    function automatic int pat_eff_len(input int p);
        int n;
        n = pat_len(p);
        if (n > MAX_PATTERN_LEN)
            n = MAX_PATTERN_LEN;
        if (n > TEXT_SLOTS)
            n = TEXT_SLOTS;
        return n;
    endfunction

    // Character i of pattern p, counted from the left of the full text
    function automatic logic [7:0] pat_char(input int p, input int i);
        logic [8*TEXT_SLOTS-1:0] s;
        int raw;
        s   = pat_text(p);
        raw = pat_len(p);
        if (i < 0 || i >= raw)
            return 8'h00;
        return s[8*(raw-1-i) +: 8];
    endfunction

    // One unit of progress for one pattern; c is already case-folded
    function automatic spm_lane_t spm_lane_step(input int p, input prog_t prog,
                                                input logic [UNIT_W-1:0] c);
        spm_lane_t r;
        int len;
        int n;
        len = pat_eff_len(p);
        n   = int'(prog);
        if (len == 0)
            n = 0;
        else if (c == BACKSLASH)
            n = 1;
        else if (n > 0 && n < len && c == {8'h00, pat_char(p, n)})
            n = n + 1;
        else
            n = 0;
        r.hit = 1'b0;
        if (len != 0 && n >= len)
        begin
            r.hit = 1'b1;
            n     = 0;
        end
        r.prog = PROG_W'(n);
        return r;
    endfunction

endpackage

// ===== src/spm_unit_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_unit_if
// Input request channel: one code unit of the pipe name.
// ----------------------------------------------------------------------------
interface spm_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== src/spm_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_result_if
// Output request channel: verdict for one pipe name.
// ----------------------------------------------------------------------------
interface spm_result_if;
    logic valid;
    logic ready;
    logic suspicious;

    modport source (output valid, output suspicious, input ready);
    modport sink   (input valid, input suspicious, output ready);
endinterface

// ===== src/suspicious_pipe_prefix_matcher_top.sv =====
`timescale 1ns / 1ps
// A code unit is registered on acceptance and matched from the input register;
//   the verdict for a name is registered when its last unit is matched.
// Throughput: one code unit per cycle, limited only by the output register
//   when a verdict waits and the next name's last unit arrives.
// Reset: rst_n (async, active low) clears all match progress, the hit flag
//   and both valid flags; the block is ready straight out of reset.
// ----------------------------------------------------------------------------
// suspicious_pipe_prefix_matcher_top
// Flags a pipe name that holds one of a fixed set of prefixes after any
// backslash, ignoring ASCII case.
// ----------------------------------------------------------------------------
module suspicious_pipe_prefix_matcher_top (
    input  logic         clk,
    input  logic         rst_n,
    spm_unit_if.sink     unit_ch,
    spm_result_if.source result_ch
);
    import spm_pkg::*;

    `include "suspicious_pipe_prefix_matcher_top_assert.svh"

    // Input register: holds one request until the match stage takes it
    logic        in_valid_reg;
    logic [15:0] unit_reg;
    logic        last_reg;

    // Result register
    logic        out_valid_reg;
    logic        susp_reg;

    logic        step;
    logic        core_susp;
    spm_status_t core_status;

    // The match stage only stalls on a last unit whose verdict cannot be
    // parked because the result register is still full.
    assign step = in_valid_reg && (!last_reg || !out_valid_reg || result_ch.ready);

    assign unit_ch.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (unit_ch.ready)
            in_valid_reg <= unit_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (unit_ch.ready && unit_ch.valid)
        begin
            unit_reg <= unit_ch.code_unit;
            last_reg <= unit_ch.last_unit;
        end
    end

    spm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_unit  (unit_reg),
        .last_unit  (last_reg),
        .step       (step),
        .suspicious (core_susp),
        .status     (core_status)
    );

    // Verdict is loaded on the last unit; drained when the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && last_reg)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
            susp_reg <= core_susp;
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.suspicious = susp_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SPM_ASSERT_NEXT(a_clear_after_last, step && last_reg,
        !core_status.hit_seen && !core_status.busy, "state not cleared after last unit")
    `SPM_ASSERT_SAME(a_stall_cause, !unit_ch.ready,
        in_valid_reg && last_reg && out_valid_reg && !result_ch.ready,
        "input stalled without a blocked verdict")
    `SPM_ASSERT_SAME(a_verdict_source, $rose(out_valid_reg),
        $past(step) && $past(last_reg), "verdict raised without a last unit")

endmodule

// ===== src/spm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_core
// Per-pattern progress lanes and the sticky hit flag.
// ----------------------------------------------------------------------------
module spm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         code_unit,
    input  logic                last_unit,
    input  logic                step,
    output logic                suspicious,
    output spm_pkg::spm_status_t status
);
    import spm_pkg::*;

    prog_t                   prog_reg  [NUM_PATTERNS];
    prog_t                   prog_next [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] lane_hit;
    logic [NUM_PATTERNS-1:0] lane_busy;
    logic                    hit_seen_reg;
    logic                    hit_seen_next;
    logic [UNIT_W-1:0]       folded;

    // ASCII A-Z only
    assign folded = (code_unit >= UPPER_A && code_unit <= UPPER_Z) ?
                    code_unit + CASE_OFS : code_unit;

    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_lane
        spm_lane_t r;
        assign r            = spm_lane_step(p, prog_reg[p], folded);
        assign prog_next[p] = r.prog;
        assign lane_hit[p]  = r.hit;
        assign lane_busy[p] = |prog_reg[p];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                prog_reg[p] <= '0;
            else if (step)
                prog_reg[p] <= last_unit ? '0 : prog_next[p];
        end
    end

    assign hit_seen_next = hit_seen_reg | (|lane_hit);
    assign suspicious    = hit_seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_seen_reg <= 1'b0;
        else if (step)
            hit_seen_reg <= last_unit ? 1'b0 : hit_seen_next;
    end

    assign status.hit_seen = hit_seen_reg;
    assign status.busy     = |lane_busy;

endmodule
